FILE: design/ptic_pkg.sv
// Shared types, constants and CRC helpers for the PNG text chunk inserter.
package ptic_pkg;

   localparam int CNT_W = 6;

   localparam logic [31:0] TYPE_IEND = 32'h49454E44;
   localparam logic [31:0] TYPE_TEXT = 32'h74455874;
   localparam logic [31:0] IEND_CRC  = 32'hAE426082;
   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES  = 32'hFFFFFFFF;
   localparam logic [31:0] SKIP_SAT  = 32'hFFFFFFFF;
   localparam logic [3:0]  CHUNK_OVERHEAD = 4'd12;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
      logic       end_of_image;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       was_modified;
   } rsp_type;

   typedef enum logic [2:0] {
      MODE_SIG    = 3'd0,
      MODE_HEADER = 3'd1,
      MODE_SKIP   = 3'd2,
      MODE_PASS   = 3'd3,
      MODE_DROP   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      CMD_BYTE   = 2'd0,
      CMD_HEADER = 2'd1,
      CMD_INSERT = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [7:0]       data_byte;
      logic             last;
      logic [3:0]       hdr_cnt;
      logic [63:0]      hold;
      logic [CNT_W-1:0] text_cnt;
      logic [31:0]      crc;
   } cmd_type;

   typedef struct packed {
      logic             en;
      logic [CNT_W-1:0] addr;
      logic [7:0]       data;
   } text_wr_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h89;
         3'd1:    b = 8'h50;
         3'd2:    b = 8'h4E;
         3'd3:    b = 8'h47;
         3'd4:    b = 8'h0D;
         3'd5:    b = 8'h0A;
         3'd6:    b = 8'h1A;
         3'd7:    b = 8'h0A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] crc_word(input logic [31:0] c_in, input logic [31:0] w);
      logic [31:0] c;
      c = crc_byte(c_in, w[31:24]);
      c = crc_byte(c, w[23:16]);
      c = crc_byte(c, w[15:8]);
      c = crc_byte(c, w[7:0]);
      return c;
   endfunction

   // big-endian byte pick: index 0 is the most significant byte
   function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = w[31:24];
         2'd1:    b = w[23:16];
         2'd2:    b = w[15:8];
         2'd3:    b = w[7:0];
         default: b = w[7:0];
      endcase
      return b;
   endfunction

   localparam logic [31:0] CRC_TEXT_SEED = crc_word(CRC_ONES, TYPE_TEXT);

endpackage

FILE: design/ptic_cmd_fifo.sv
// Short command queue between the parser front end and the byte emitter.
module ptic_cmd_fifo
   import ptic_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full     = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/ptic_front.sv
// Front end: accepts requests, stores text, runs the CRC and walks PNG chunks.
module ptic_front
   import ptic_pkg::*;
#(
   parameter int TEXT_MAX = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        cmd_push,
   output cmd_type     cmd_data,
   input  logic        cmd_full,
   input  logic        insert_done,
   output text_wr_type text_wr
);

   mode_type         mode_ff, mode_in;
   logic [2:0]       sig_cnt_ff, sig_cnt_in;
   logic [63:0]      hold_ff, hold_in, hold_next;
   logic [2:0]       hcnt_ff, hcnt_in;
   logic [31:0]      skip_ff, skip_in;
   logic [32:0]      skip_sum;
   logic [CNT_W-1:0] tcnt_ff, tcnt_in;
   logic [31:0]      crc_ff, crc_in;
   logic             busy_ff, busy_in;
   logic             accept;
   logic             eoi;
   logic [7:0]       b;

   assign req_ready = !busy_ff && !cmd_full;
   assign accept    = req_valid && req_ready;
   assign eoi       = req_data.end_of_image;
   assign b         = req_data.data_byte;
   assign hold_next = {hold_ff[55:0], b};
   assign skip_sum  = {1'b0, hold_next[63:32]} + 33'd4;

   always_comb begin
      mode_in    = mode_ff;
      sig_cnt_in = sig_cnt_ff;
      hold_in    = hold_ff;
      hcnt_in    = hcnt_ff;
      skip_in    = skip_ff;
      tcnt_in    = tcnt_ff;
      crc_in     = crc_ff;
      busy_in    = busy_ff;
      cmd_push   = 1'b0;
      cmd_data   = '0;
      text_wr    = '0;
      cmd_data.kind      = CMD_BYTE;
      cmd_data.data_byte = b;
      cmd_data.last      = eoi;
      cmd_data.hold      = hold_next;
      cmd_data.hdr_cnt   = {1'b0, hcnt_ff} + 4'd1;
      cmd_data.text_cnt  = tcnt_ff;
      cmd_data.crc       = crc_ff ^ CRC_ONES;

      if (accept) begin
         if (!req_data.op) begin
            // store text while room remains; extra bytes are dropped
            if (tcnt_ff < CNT_W'(TEXT_MAX)) begin
               text_wr.en   = 1'b1;
               text_wr.addr = tcnt_ff;
               text_wr.data = b;
               tcnt_in      = tcnt_ff + 1'b1;
               crc_in       = crc_byte(crc_ff, b);
            end
         end else begin
            case (mode_ff)
               MODE_SIG: begin
                  cmd_push = 1'b1;
                  if (b == sig_byte(sig_cnt_ff)) begin
                     sig_cnt_in = sig_cnt_ff + 1'b1;
                     if (sig_cnt_ff == 3'd7) begin
                        mode_in = MODE_HEADER;
                     end
                  end else begin
                     mode_in = MODE_PASS;
                  end
               end
               MODE_HEADER: begin
                  hold_in = hold_next;
                  hcnt_in = hcnt_ff + 1'b1;
                  if (hcnt_ff == 3'd7) begin
                     cmd_push = 1'b1;
                     hold_in  = '0;
                     hcnt_in  = '0;
                     if (hold_next[31:0] == TYPE_IEND && tcnt_ff != '0) begin
                        cmd_data.kind = CMD_INSERT;
                        busy_in       = 1'b1;
                        mode_in       = MODE_DROP;
                     end else if (hold_next[31:0] == TYPE_IEND) begin
                        cmd_data.kind = CMD_HEADER;
                        mode_in       = MODE_PASS;
                     end else begin
                        cmd_data.kind = CMD_HEADER;
                        skip_in       = skip_sum[32] ? SKIP_SAT : skip_sum[31:0];
                        mode_in       = MODE_SKIP;
                     end
                  end else if (eoi) begin
                     // truncated header: release what is held
                     cmd_push      = 1'b1;
                     cmd_data.kind = CMD_HEADER;
                  end
               end
               MODE_SKIP: begin
                  cmd_push = 1'b1;
                  skip_in  = skip_ff - 1'b1;
                  if (skip_ff == 32'd1) begin
                     mode_in = MODE_HEADER;
                  end
               end
               MODE_PASS: begin
                  cmd_push = 1'b1;
               end
               MODE_DROP: begin
                  cmd_push = 1'b0;
               end
               default: begin
                  cmd_push = 1'b1;
               end
            endcase
            if (eoi) begin
               mode_in    = MODE_SIG;
               sig_cnt_in = '0;
               hold_in    = '0;
               hcnt_in    = '0;
               skip_in    = '0;
               tcnt_in    = '0;
               crc_in     = CRC_TEXT_SEED;
            end
         end
      end
      if (insert_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_SIG;
         sig_cnt_ff <= '0;
         hold_ff    <= '0;
         hcnt_ff    <= '0;
         skip_ff    <= '0;
         tcnt_ff    <= '0;
         crc_ff     <= CRC_TEXT_SEED;
         busy_ff    <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         sig_cnt_ff <= sig_cnt_in;
         hold_ff    <= hold_in;
         hcnt_ff    <= hcnt_in;
         skip_ff    <= skip_in;
         tcnt_ff    <= tcnt_in;
         crc_ff     <= crc_in;
         busy_ff    <= busy_in;
      end
   end

endmodule

FILE: design/ptic_back.sv
// Back end: text store, command sequencer and registered output stage.
module ptic_back
   import ptic_pkg::*;
#(
   parameter int TEXT_MAX = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  text_wr_type text_wr,
   input  logic        cmd_empty,
   input  cmd_type     cmd_data,
   output logic        cmd_pop,
   output logic        insert_done,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int IDX_W = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
   localparam int POS_W = $clog2(TEXT_MAX + 24);
   localparam int EXT_W = CNT_W + 1;

   logic [7:0]       store [TEXT_MAX];
   logic [7:0]       rd_ff;
   logic [EXT_W-1:0] rd_addr_x;

   cmd_type          cur_ff, cur_in;
   logic             active_ff, active_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_free;
   logic             fire;
   logic             cmd_end;
   rsp_type          gen;
   logic [2:0]       hdr_sel;
   logic [2:0]       hdr_top;
   logic [EXT_W-1:0] pos_x;
   logic [EXT_W-1:0] n_x;
   logic [EXT_W-1:0] tail_x;
   logic [31:0]      tail_word;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign fire        = active_ff && out_free;
   assign cmd_pop     = !cmd_empty && (!active_ff || (fire && cmd_end));
   assign insert_done = fire && cmd_end && (cur_ff.kind == CMD_INSERT);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   assign pos_x   = EXT_W'(pos_ff);
   assign n_x     = {1'b0, cur_ff.text_cnt};
   assign tail_x  = pos_x - 7'd8 - n_x;
   assign hdr_top = cur_ff.hdr_cnt[2:0] - 3'd1;
   assign hdr_sel = hdr_top - pos_ff[2:0];

   always_comb begin
      case (tail_x[3:2])
         2'd0:    tail_word = cur_ff.crc;
         2'd1:    tail_word = 32'd0;
         2'd2:    tail_word = TYPE_IEND;
         2'd3:    tail_word = IEND_CRC;
         default: tail_word = 32'd0;
      endcase
   end

   // byte generator for the command in hand
   always_comb begin
      gen     = '0;
      cmd_end = 1'b1;
      case (cur_ff.kind)
         CMD_BYTE: begin
            gen.out_byte = cur_ff.data_byte;
            gen.out_last = cur_ff.last;
         end
         CMD_HEADER: begin
            cmd_end      = (pos_ff[2:0] == hdr_top);
            gen.out_byte = cur_ff.hold[{hdr_sel, 3'b000} +: 8];
            gen.out_last = cur_ff.last && cmd_end;
         end
         CMD_INSERT: begin
            cmd_end          = (pos_x == n_x + 7'd23);
            gen.was_modified = 1'b1;
            gen.out_last     = cmd_end;
            if (pos_x < 7'd4) begin
               gen.out_byte = word_byte({{(32-CNT_W){1'b0}}, cur_ff.text_cnt}, pos_x[1:0]);
            end else if (pos_x < 7'd8) begin
               gen.out_byte = word_byte(TYPE_TEXT, pos_x[1:0]);
            end else if (pos_x < n_x + 7'd8) begin
               gen.out_byte = rd_ff;
            end else begin
               gen.out_byte = word_byte(tail_word, tail_x[1:0]);
            end
         end
         default: begin
            gen = '0;
         end
      endcase
   end

   always_comb begin
      cur_in    = cmd_pop ? cmd_data : cur_ff;
      active_in = active_ff;
      pos_in    = pos_ff;
      if (cmd_pop) begin
         active_in = 1'b1;
         pos_in    = '0;
      end else if (fire) begin
         if (cmd_end) begin
            active_in = 1'b0;
         end
         pos_in = pos_ff + 1'b1;
      end
      rsp_in       = fire ? gen : rsp_ff;
      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // prefetch the text byte for the next position
   assign rd_addr_x = EXT_W'(pos_in) - 7'd8;

   always_ff @(posedge clock) begin
      if (text_wr.en) begin
         store[text_wr.addr[IDX_W-1:0]] <= text_wr.data;
      end
      rd_ff <= store[rd_addr_x[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

endmodule

FILE: design/png_text_chunk_inserter_unit.sv
// Path: a passed-through PNG byte goes from its accepted request into a queue slot, then into
// the back end's command register, then the output register behind rsp_valid; queued bytes
// and output stalls delay it further. Throughput: one byte per cycle while streaming and the
// output is ready; a held chunk header drains as up to 8 bytes, one byte per cycle.
// The inserted tEXt plus IEND burst is text count + 24 bytes long; requests hold off meanwhile.
// Reset (synchronous, active high) clears parser, queue and output; text store is not cleared.
module png_text_chunk_inserter_unit
   import ptic_pkg::*;
#(
   parameter int TEXT_MAX = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // front to queue
   logic        cmd_push;
   cmd_type     cmd_in_data;
   logic        cmd_full;
   // queue to back
   logic        cmd_pop;
   cmd_type     cmd_out_data;
   logic        cmd_empty;
   // back to front: insert burst finished, release the request side
   logic        insert_done;
   // front writes text bytes straight into the back end's store
   text_wr_type text_wr;

   // Classify each request: text, signature, header hold, skip, pass or drop.
   ptic_front #(
      .TEXT_MAX(TEXT_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_in_data),
      .cmd_full   (cmd_full),
      .insert_done(insert_done),
      .text_wr    (text_wr)
   );

   // Decouple parsing from emission so each side stalls on its own.
   ptic_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(cmd_in_data),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .pop_data (cmd_out_data),
      .empty    (cmd_empty)
   );

   // Emit bytes: single pass bytes, released headers, the inserted chunk burst.
   ptic_back #(
      .TEXT_MAX(TEXT_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .text_wr    (text_wr),
      .cmd_empty  (cmd_empty),
      .cmd_data   (cmd_out_data),
      .cmd_pop    (cmd_pop),
      .insert_done(insert_done),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // Never push into a full queue.
   assert property (@(posedge clock) disable iff (reset) !(cmd_push && cmd_full))
      else $error("command pushed into full queue");

   // Never pop an empty queue.
   assert property (@(posedge clock) disable iff (reset) !(cmd_pop && cmd_empty))
      else $error("command popped from empty queue");

   // Requests stay held off until the insert burst has finished.
   assert property (@(posedge clock) disable iff (reset) insert_done |-> !req_ready)
      else $error("request side open during insert burst");

   // No text byte lands in the store while the burst reads it.
   assert property (@(posedge clock) disable iff (reset) insert_done |-> !text_wr.en)
      else $error("text store written during insert burst");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the PNG tEXt chunk inserter: directed table plus random images.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ptic_pkg::*;

   localparam int TEXT_CAP     = 32;
   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 270;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int REPORT_MAX   = 10;

   // PNG file signature, first byte in the top lane
   localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;

   // How a stimulus row gets its expected output: from the predictor, or typed in the table
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NO_OUT,
      ROW_ONE_OUT
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      req_type      req;
      rsp_type      rsp;
   } stim_row_type;

   // Image shapes for the random part; the first few images walk them in order
   typedef enum int {
      IMG_INSERT,
      IMG_OVERFLOW,
      IMG_HUGE_LEN,
      IMG_TRUNC_HDR,
      IMG_NO_IEND,
      IMG_NO_TEXT,
      IMG_BAD_SIG,
      IMG_NOISE
   } img_shape_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Side band of the request on the wire: how its output is to be expected
   row_kind_type row_kind = ROW_PREDICT;
   rsp_type      row_rsp  = '0;

   stim_row_type stim_q[$];
   rsp_type      png_out_q[$];
   int           fail_count  = 0;
   int           cycle_count = 0;

   // Predictor state: one copy of what the block keeps per image
   logic [7:0]  text_mem [TEXT_CAP];
   logic [5:0]  text_len;
   logic [31:0] text_crc_q;
   mode_type    mode_q;
   int          magic_cnt;
   logic [63:0] hdr_q;
   int          hdr_cnt;
   logic [31:0] skip_q;

   png_text_chunk_inserter_unit #(
      .TEXT_MAX (TEXT_CAP)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // CRC-32 as PNG uses it, reflected, one byte or one big-endian word at a time
   // ---------------------------------------------------------------------------------------
   function automatic logic [31:0] crc32_feed(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      int          k;
      r = c ^ {24'h0, b};
      for (k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [31:0] crc32_word(logic [31:0] c, logic [31:0] w);
      logic [31:0] r;
      int          i;
      r = c;
      for (i = 3; i >= 0; i--) begin
         r = crc32_feed(r, w[8*i +: 8]);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Predictor: walk the PNG stream the way the block does and queue the bytes it must send
   // ---------------------------------------------------------------------------------------
   function automatic void restart_image();
      text_len   = '0;
      text_crc_q = crc32_word(CRC_ONES, TYPE_TEXT);
      mode_q     = MODE_SIG;
      magic_cnt  = 0;
      hdr_q      = '0;
      hdr_cnt    = 0;
      skip_q     = '0;
   endfunction

   function automatic void emit_png(logic [7:0] b, logic last, logic modified);
      rsp_type r;
      r.out_byte     = b;
      r.out_last     = last;
      r.was_modified = modified;
      png_out_q.push_back(r);
   endfunction

   // Inserted words go out big-endian; last marks only the final byte
   function automatic void emit_word(logic [31:0] w, logic last);
      int i;
      for (i = 3; i >= 0; i--) begin
         emit_png(w[8*i +: 8], last && (i == 0), 1'b1);
      end
   endfunction

   // Hand back the held header bytes, oldest first
   function automatic void release_hold(logic eoi);
      int i;
      for (i = 0; i < hdr_cnt; i++) begin
         emit_png(hdr_q[8*(hdr_cnt-1-i) +: 8], eoi && (i == hdr_cnt - 1), 1'b0);
      end
   endfunction

   function automatic void advance_png(req_type r);
      logic [31:0] chunk_len;
      logic [31:0] chunk_type;
      int          i;
      if (!r.op) begin
         // Text byte: store and fold into the CRC, drop once the store is full
         if (text_len < TEXT_CAP) begin
            text_mem[text_len[4:0]] = r.data_byte;
            text_len                = text_len + 6'd1;
            text_crc_q              = crc32_feed(text_crc_q, r.data_byte);
         end
         return;
      end
      case (mode_q)
         MODE_SIG: begin
            emit_png(r.data_byte, r.end_of_image, 1'b0);
            if (r.data_byte == PNG_MAGIC[63-8*magic_cnt -: 8]) begin
               magic_cnt++;
               if (magic_cnt == 8) mode_q = MODE_HEADER;
            end else begin
               mode_q = MODE_PASS;
            end
         end
         MODE_HEADER: begin
            hdr_q = {hdr_q[55:0], r.data_byte};
            hdr_cnt++;
            if (hdr_cnt >= 8) begin
               chunk_len  = hdr_q[63:32];
               chunk_type = hdr_q[31:0];
               if (chunk_type == TYPE_IEND && text_len != 0) begin
                  // Splice in tEXt, then a fresh IEND, and swallow the rest of the image
                  emit_word({26'd0, text_len}, 1'b0);
                  emit_word(TYPE_TEXT, 1'b0);
                  for (i = 0; i < text_len; i++) begin
                     emit_png(text_mem[i], 1'b0, 1'b1);
                  end
                  emit_word(~text_crc_q, 1'b0);
                  emit_word(32'd0, 1'b0);
                  emit_word(TYPE_IEND, 1'b0);
                  emit_word(~crc32_word(CRC_ONES, TYPE_IEND), 1'b1);
                  mode_q = MODE_DROP;
               end else if (chunk_type == TYPE_IEND) begin
                  release_hold(r.end_of_image);
                  mode_q = MODE_PASS;
               end else begin
                  release_hold(r.end_of_image);
                  skip_q = (chunk_len > 32'hFFFFFFFB) ? SKIP_SAT : chunk_len + 32'd4;
                  mode_q = (skip_q == 0) ? MODE_HEADER : MODE_SKIP;
               end
               hdr_q   = '0;
               hdr_cnt = 0;
            end else if (r.end_of_image) begin
               release_hold(1'b1);
            end
         end
         MODE_SKIP: begin
            emit_png(r.data_byte, r.end_of_image, 1'b0);
            if (skip_q != 0) skip_q = skip_q - 32'd1;
            if (skip_q == 0) mode_q = MODE_HEADER;
         end
         MODE_DROP: begin
         end
         default: begin
            emit_png(r.data_byte, r.end_of_image, 1'b0);
         end
      endcase
      if (r.end_of_image) restart_image();
   endfunction

   // Run the predictor; rows with a typed answer replace what it queued with that answer
   function automatic void take_request(row_kind_type kind, req_type r, rsp_type typed);
      int n_before;
      n_before = png_out_q.size();
      advance_png(r);
      if (kind != ROW_PREDICT) begin
         while (png_out_q.size() > n_before) void'(png_out_q.pop_back());
         if (kind == ROW_ONE_OUT) png_out_q.push_back(typed);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------------
   function automatic void report_mismatch(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("[%0t] %s: expected byte %02h last %0b mod %0b, got byte %02h last %0b mod %0b",
                  $realtime, what, want.out_byte, want.out_last, want.was_modified,
                  got.out_byte, got.out_last, got.was_modified);
      end
   endfunction

   function automatic void check_png_byte(rsp_type got);
      rsp_type want;
      if (png_out_q.size() == 0) begin
         report_mismatch("byte with nothing expected", '0, got);
         return;
      end
      want = png_out_q.pop_front();
      if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
          got.was_modified !== want.was_modified) begin
         report_mismatch("output byte mismatch", want, got);
      end
   endfunction

   // Sample both channels at the rising edge; take the request before the output so
   // the order within the step never matters
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) take_request(row_kind, req_data, row_rsp);
         if (rsp_valid && rsp_ready) check_png_byte(rsp_data);
      end
   end

   // Watchdog: give up on a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------------------------
   function automatic void put_row(row_kind_type kind, logic op, logic [7:0] b, logic eoi,
                                   logic [7:0] exp_byte, logic exp_last);
      stim_row_type r;
      r.kind                 = kind;
      r.req.op               = op;
      r.req.data_byte        = b;
      r.req.end_of_image     = eoi;
      r.rsp.out_byte         = exp_byte;
      r.rsp.out_last         = exp_last;
      r.rsp.was_modified     = 1'b0;
      stim_q.push_back(r);
   endfunction

   function automatic void add_req(logic op, logic [7:0] b, logic eoi);
      put_row(ROW_PREDICT, op, b, eoi, 8'h00, 1'b0);
   endfunction

   function automatic void add_word(logic [31:0] w);
      int i;
      for (i = 3; i >= 0; i--) add_req(1'b1, w[8*i +: 8], 1'b0);
   endfunction

   // Mark the newest request as the last byte of the image
   function automatic void close_image();
      stim_row_type r;
      r = stim_q.pop_back();
      r.req.end_of_image = 1'b1;
      stim_q.push_back(r);
   endfunction

   function automatic logic [31:0] random_type();
      logic [31:0] t;
      t = $urandom;
      if (t == TYPE_IEND) t[0] = ~t[0];
      return t;
   endfunction

   // Ordinary chunk: header, data, CRC bytes (the block never checks chunk CRCs)
   function automatic void add_chunk(int len);
      int i;
      add_word(32'(len));
      add_word(random_type());
      for (i = 0; i < len + 4; i++) add_req(1'b1, 8'($urandom_range(0, 255)), 1'b0);
   endfunction

   function automatic void build_image(img_shape_type shape);
      int          n_text;
      int          n_chunks;
      int          bad_at;
      int          i;
      logic [7:0]  b;
      if (shape == IMG_NOISE) begin
         // Short burst of junk, text and image bytes mixed
         n_text = $urandom_range(1, 6);
         for (i = 0; i < n_text; i++) begin
            add_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
         end
         add_req(1'b1, 8'($urandom_range(0, 255)), 1'b1);
         return;
      end
      case (shape)
         IMG_OVERFLOW: n_text = $urandom_range(TEXT_CAP + 1, TEXT_CAP + 8);
         IMG_NO_TEXT:  n_text = 0;
         default:      n_text = $urandom_range(1, 6);
      endcase
      // end_of_image rides along on text bytes at random; the block must ignore it there
      for (i = 0; i < n_text; i++) begin
         add_req(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      bad_at = (shape == IMG_BAD_SIG) ? $urandom_range(0, 7) : 8;
      for (i = 0; i < 8; i++) begin
         b = PNG_MAGIC[63-8*i -: 8];
         if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
         add_req(1'b1, b, 1'b0);
      end
      // Now and then slip text in while the image streams
      if ($urandom_range(0, 4) == 0 && shape != IMG_NO_TEXT) begin
         n_text = $urandom_range(1, 2);
         for (i = 0; i < n_text; i++) add_req(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      end
      n_chunks = $urandom_range(0, 2);
      if (shape == IMG_NO_IEND && n_chunks == 0) n_chunks = 1;
      for (i = 0; i < n_chunks; i++) add_chunk($urandom_range(0, 4));
      case (shape)
         IMG_HUGE_LEN: begin
            // Length near 2^32: skip saturates and the image ends inside the chunk
            add_word(32'hFFFFFFFC + 32'($urandom_range(0, 3)));
            add_word(random_type());
            n_text = $urandom_range(1, 4);
            for (i = 0; i < n_text; i++) add_req(1'b1, 8'($urandom_range(0, 255)), 1'b0);
         end
         IMG_TRUNC_HDR: begin
            n_text = $urandom_range(1, 7);
            for (i = 0; i < n_text; i++) add_req(1'b1, 8'($urandom_range(0, 255)), 1'b0);
         end
         IMG_NO_IEND: begin
         end
         default: begin
            add_word(32'd0);
            add_word(TYPE_IEND);
            add_word(32'hAE426082);
            if ($urandom_range(0, 2) == 0) begin
               n_text = $urandom_range(1, 3);
               for (i = 0; i < n_text; i++) add_req(1'b1, 8'($urandom_range(0, 255)), 1'b0);
            end
         end
      endcase
      close_image();
   endfunction

   // Idle length: mostly none or short, a few long; none at all in a calm stretch
   function automatic int idle_cycles(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Output side: hold ready for a while, then stall for a random gap
   // ---------------------------------------------------------------------------------------
   initial begin
      bit calm;
      int n;
      calm = 1'b0;
      wait (!reset);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         if ($urandom_range(0, 7) == 0) calm = ~calm;
         n = idle_cycles(calm);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Input side: build the request list, reset once, then drive every request
   // ---------------------------------------------------------------------------------------
   initial begin
      int            n_directed;
      int            img_idx;
      int            gap;
      bit            calm;
      stim_row_type  row;
      img_shape_type shape;

      restart_image();

      // Directed table.  Typed answers are plain pass-through or silence; the rest predicted.
      //       kind         op    byte   eoi   | out    last
      // text, extremes of the byte
      put_row(ROW_NO_OUT,  1'b0, 8'hFF, 1'b0,  8'h00, 1'b0);
      put_row(ROW_NO_OUT,  1'b0, 8'h00, 1'b0,  8'h00, 1'b0);
      // signature passes straight through
      put_row(ROW_ONE_OUT, 1'b1, 8'h89, 1'b0,  8'h89, 1'b0);
      put_row(ROW_ONE_OUT, 1'b1, 8'h50, 1'b0,  8'h50, 1'b0);
      // text arriving mid-image, end_of_image on it must be ignored
      put_row(ROW_NO_OUT,  1'b0, 8'h41, 1'b1,  8'h00, 1'b0);
      put_row(ROW_ONE_OUT, 1'b1, 8'h4E, 1'b0,  8'h4E, 1'b0);
      put_row(ROW_ONE_OUT, 1'b1, 8'h47, 1'b0,  8'h47, 1'b0);
      put_row(ROW_ONE_OUT, 1'b1, 8'h0D, 1'b0,  8'h0D, 1'b0);
      put_row(ROW_ONE_OUT, 1'b1, 8'h0A, 1'b0,  8'h0A, 1'b0);
      put_row(ROW_ONE_OUT, 1'b1, 8'h1A, 1'b0,  8'h1A, 1'b0);
      put_row(ROW_ONE_OUT, 1'b1, 8'h0A, 1'b0,  8'h0A, 1'b0);
      // IEND header: held silently, the last byte fires the tEXt + IEND burst
      put_row(ROW_NO_OUT,  1'b1, 8'h00, 1'b0,  8'h00, 1'b0);
      put_row(ROW_NO_OUT,  1'b1, 8'h00, 1'b0,  8'h00, 1'b0);
      put_row(ROW_NO_OUT,  1'b1, 8'h00, 1'b0,  8'h00, 1'b0);
      put_row(ROW_NO_OUT,  1'b1, 8'h00, 1'b0,  8'h00, 1'b0);
      put_row(ROW_NO_OUT,  1'b1, 8'h49, 1'b0,  8'h00, 1'b0);
      put_row(ROW_NO_OUT,  1'b1, 8'h45, 1'b0,  8'h00, 1'b0);
      put_row(ROW_NO_OUT,  1'b1, 8'h4E, 1'b0,  8'h00, 1'b0);
      put_row(ROW_PREDICT, 1'b1, 8'h44, 1'b0,  8'h00, 1'b0);
      // after insertion the old IEND CRC is dropped, end_of_image still clears
      put_row(ROW_NO_OUT,  1'b1, 8'hAE, 1'b0,  8'h00, 1'b0);
      put_row(ROW_NO_OUT,  1'b1, 8'h82, 1'b1,  8'h00, 1'b0);
      // no text, bad signature on the second byte, image ends there
      put_row(ROW_ONE_OUT, 1'b1, 8'h89, 1'b0,  8'h89, 1'b0);
      put_row(ROW_ONE_OUT, 1'b1, 8'hFF, 1'b1,  8'hFF, 1'b1);
      n_directed = stim_q.size();

      // Random images: every shape once, then mostly well-formed insertions
      img_idx = 0;
      while (stim_q.size() < n_directed + RANDOM_ITEMS) begin
         if (img_idx <= int'(IMG_NOISE)) begin
            shape = img_shape_type'(img_idx);
         end else begin
            case ($urandom_range(0, 15))
               7:       shape = IMG_OVERFLOW;
               8:       shape = IMG_HUGE_LEN;
               9:       shape = IMG_TRUNC_HDR;
               10:      shape = IMG_NO_IEND;
               11:      shape = IMG_NO_TEXT;
               12:      shape = IMG_BAD_SIG;
               13:      shape = IMG_NOISE;
               default: shape = IMG_INSERT;
            endcase
         end
         build_image(shape);
         img_idx++;
      end

      // Hold reset for its cycles, release it away from the rising edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      calm = 1'b0;
      @(negedge clock);
      foreach (stim_q[i]) begin
         row = stim_q[i];
         if ($urandom_range(0, 31) == 0) calm = ~calm;
         gap = idle_cycles(calm);
         // Drop valid for the gap; otherwise keep it high straight into the next request
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= row.req;
         row_kind  <= row.kind;
         row_rsp   <= row.rsp;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b0;

      // Drain: wait for every expected byte, then watch a while for strays
      while (png_out_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      fail_count += png_out_q.size();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: png_text_chunk_inserter_unit.f
design/ptic_pkg.sv
design/ptic_cmd_fifo.sv
design/ptic_front.sv
design/ptic_back.sv
design/png_text_chunk_inserter_unit.sv
tb/sv/tb.sv
